>>> sv/pc_pkg.sv
// Shared constants and width helpers for the streaming correlation block.
`timescale 1ns / 1ps
package pc_pkg;

    localparam int MAX_SAMPLES_DEF = 65536;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SUM_CAP = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int CORR_W = 16;
    localparam int QUOT_W = 18;
    localparam int DIV_EXTRA = 80;

    function automatic int cnt_width(input int max_s);
        return $clog2(max_s + 1);
    endfunction

    function automatic int cap_width(input int w);
        return (w > SUM_CAP) ? SUM_CAP : w;
    endfunction

    function automatic int sx_width(input int max_s, input int sb);
        return cap_width(sb + cnt_width(max_s));
    endfunction

    function automatic int sxx_width(input int max_s, input int sb);
        return cap_width(2 * sb - 2 + cnt_width(max_s));
    endfunction

    function automatic int sxy_width(input int max_s, input int sb);
        return cap_width(2 * sb - 1 + cnt_width(max_s));
    endfunction

    function automatic int entry_width(input int max_s, input int sb);
        return cnt_width(max_s) + 2 * sx_width(max_s, sb) + 2 * sxx_width(max_s, sb)
            + sxy_width(max_s, sb);
    endfunction

endpackage

>>> sv/pearson_correlation.sv
// Top level of the streaming Pearson correlation block.
//
//  channel   direction  ports
//  s_        in         s_valid, s_ready, s_x_sample, s_y_sample, s_last_sample
//  m_        out        m_valid, m_ready, m_correlation, m_zero_spread, m_pair_count
//
// Sample pairs are taken one per clock while the snapshot queue has room.
// Each series end occupies the back end for six 64-bit shift-add products,
// two 32-step square roots and up to 140 division steps.
// Two finished series can wait in the queue while the back end works.
// Reset is synchronous and clears all sums, the queue and the result valid flag.
`timescale 1ns / 1ps
module pearson_correlation #(
    parameter int MAX_SAMPLES = pc_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = pc_pkg::SAMPLE_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_x_sample,
    input  logic signed [SAMPLE_BITS-1:0] s_y_sample,
    input  logic s_last_sample,
    output logic m_valid,
    input  logic m_ready,
    output logic signed [pc_pkg::CORR_W-1:0] m_correlation,
    output logic m_zero_spread,
    output logic [pc_pkg::cnt_width(MAX_SAMPLES)-1:0] m_pair_count
);
    import pc_pkg::*;

    localparam int EW = entry_width(MAX_SAMPLES, SAMPLE_BITS);

    logic q_push, q_pop, q_full, q_empty;
    logic [EW-1:0] q_wdata, q_rdata;

    pc_front #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_x_sample(s_x_sample),
        .s_y_sample(s_y_sample),
        .s_last_sample(s_last_sample),
        .q_full(q_full),
        .q_push(q_push),
        .q_data(q_wdata)
    );

    pc_fifo #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(q_push),
        .push_data(q_wdata),
        .pop(q_pop),
        .pop_data(q_rdata),
        .full(q_full),
        .empty(q_empty)
    );

    pc_back #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .q_empty(q_empty),
        .q_data(q_rdata),
        .q_pop(q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_correlation(m_correlation),
        .m_zero_spread(m_zero_spread),
        .m_pair_count(m_pair_count)
    );

endmodule

>>> sv/pc_front.sv
// Front end: accepts sample pairs, keeps running sums, queues a snapshot per series.
`timescale 1ns / 1ps
module pc_front #(
    parameter int MAX_SAMPLES = pc_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = pc_pkg::SAMPLE_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_x_sample,
    input  logic signed [SAMPLE_BITS-1:0] s_y_sample,
    input  logic s_last_sample,
    input  logic q_full,
    output logic q_push,
    output logic [pc_pkg::entry_width(MAX_SAMPLES, SAMPLE_BITS)-1:0] q_data
);
    import pc_pkg::*;

    localparam int CW = cnt_width(MAX_SAMPLES);
    localparam int SX_W = sx_width(MAX_SAMPLES, SAMPLE_BITS);
    localparam int SXX_W = sxx_width(MAX_SAMPLES, SAMPLE_BITS);
    localparam int SXY_W = sxy_width(MAX_SAMPLES, SAMPLE_BITS);
    localparam int PW = 2 * SAMPLE_BITS;

    logic [CW-1:0] count_reg, count_next;
    logic signed [SX_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [SXX_W-1:0] sxx_reg, sxx_next, syy_reg, syy_next;
    logic signed [SXY_W-1:0] sxy_reg, sxy_next;
    logic signed [PW-1:0] xx, yy, xy;
    logic take, room;

    assign s_ready = !q_full;
    assign take = s_valid && s_ready;
    assign room = count_reg < CW'(MAX_SAMPLES);

    assign xx = s_x_sample * s_x_sample;
    assign yy = s_y_sample * s_y_sample;
    assign xy = s_x_sample * s_y_sample;

    always_comb begin
        count_next = count_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        sxx_next = sxx_reg;
        syy_next = syy_reg;
        sxy_next = sxy_reg;
        if (room) begin
            count_next = count_reg + CW'(1);
            sx_next = sx_reg + SX_W'(s_x_sample);
            sy_next = sy_reg + SX_W'(s_y_sample);
            sxx_next = sxx_reg + SXX_W'($unsigned(xx));
            syy_next = syy_reg + SXX_W'($unsigned(yy));
            sxy_next = sxy_reg + SXY_W'(xy);
        end
    end

    assign q_push = take && s_last_sample;
    assign q_data = {count_next, sx_next, sy_next, sxx_next, syy_next, sxy_next};

    always_ff @(posedge aclk) begin
        if (!aresetn || q_push) begin
            count_reg <= '0;
            sx_reg <= '0;
            sy_reg <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
        end else if (take) begin
            count_reg <= count_next;
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            sxx_reg <= sxx_next;
            syy_reg <= syy_next;
            sxy_reg <= sxy_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_SAMPLES))
        else $error("pair count passed its limit");

endmodule

>>> sv/pc_fifo.sv
// Short queue of per-series sum snapshots between front and back end.
`timescale 1ns / 1ps
module pc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pc_pkg::QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  logic [WIDTH-1:0] push_data,
    input  logic pop,
    output logic [WIDTH-1:0] pop_data,
    output logic full,
    output logic empty
);
    import pc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    assign full = fill_reg == CNT_W'(DEPTH);
    assign empty = fill_reg == '0;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue written while full");

endmodule

>>> sv/pc_back.sv
// Back end: forms the centered moments, takes two roots and divides out r.
`timescale 1ns / 1ps
module pc_back #(
    parameter int MAX_SAMPLES = pc_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = pc_pkg::SAMPLE_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_empty,
    input  logic [pc_pkg::entry_width(MAX_SAMPLES, SAMPLE_BITS)-1:0] q_data,
    output logic q_pop,
    output logic m_valid,
    input  logic m_ready,
    output logic signed [pc_pkg::CORR_W-1:0] m_correlation,
    output logic m_zero_spread,
    output logic [pc_pkg::cnt_width(MAX_SAMPLES)-1:0] m_pair_count
);
    import pc_pkg::*;

    localparam int CW = cnt_width(MAX_SAMPLES);
    localparam int SX_W = sx_width(MAX_SAMPLES, SAMPLE_BITS);
    localparam int SXX_W = sxx_width(MAX_SAMPLES, SAMPLE_BITS);
    localparam int SXY_W = sxy_width(MAX_SAMPLES, SAMPLE_BITS);
    localparam int EW = entry_width(MAX_SAMPLES, SAMPLE_BITS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_MUL, ST_CHECK, ST_NORM, ST_SQRT, ST_PROD, ST_DIV, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        P_NXX, P_XX, P_NYY, P_YY, P_NXY, P_XY
    } prod_t;

    state_t state_reg;
    prod_t step_reg;
    logic [EW-1:0] ent_reg;
    logic [CW-1:0] n_e;
    logic signed [SX_W-1:0] sx_e, sy_e;
    logic [SXX_W-1:0] sxx_e, syy_e;
    logic signed [SXY_W-1:0] sxy_e;
    logic [63:0] n64, sx64, sy64, sxx64, syy64, sxy64;
    logic [63:0] op_a, op_b;
    logic op_sub;

    logic [63:0] md_reg, mr_reg, acc_reg, a_reg, b_reg, c_reg;
    logic [63:0] v_reg, r_reg, mag_reg;
    logic signed [5:0] k_reg, ka_reg;
    logic [4:0] i_reg;
    logic second_reg, neg_reg, sat_reg, zs_reg;
    logic [30:0] root_a_reg, root_b_reg;
    logic [61:0] denom_reg, rem_reg;
    logic [QUOT_W-1:0] q_reg;
    logic [7:0] cnt_reg;

    logic m_valid_reg, zs_out_reg;
    logic signed [CORR_W-1:0] corr_reg;
    logic [CW-1:0] pc_reg;

    // Square root step
    logic [63:0] sq_bit, sq_t, sq_v_next, sq_r_next;
    logic sq_ge;
    // Division step
    logic [62:0] dv_trial;
    logic dv_ge;
    logic [61:0] dv_rem_next;
    logic [QUOT_W-1:0] dv_q_next;
    // Rounding and saturation
    logic [QUOT_W-1:0] rq;
    logic signed [CORR_W-1:0] corr_calc;
    logic signed [6:0] s_sum;
    logic out_free;

    assign {n_e, sx_e, sy_e, sxx_e, syy_e, sxy_e} = ent_reg;
    assign n64 = 64'(n_e);
    assign sx64 = 64'(sx_e);
    assign sy64 = 64'(sy_e);
    assign sxx64 = 64'(sxx_e);
    assign syy64 = 64'(syy_e);
    assign sxy64 = 64'(sxy_e);

    always_comb begin
        case (step_reg)
            P_NXX: begin op_a = n64; op_b = sxx64; op_sub = 1'b0; end
            P_XX: begin op_a = sx64; op_b = sx64; op_sub = 1'b1; end
            P_NYY: begin op_a = n64; op_b = syy64; op_sub = 1'b0; end
            P_YY: begin op_a = sy64; op_b = sy64; op_sub = 1'b1; end
            P_NXY: begin op_a = n64; op_b = sxy64; op_sub = 1'b0; end
            P_XY: begin op_a = sx64; op_b = sy64; op_sub = 1'b1; end
            default: begin op_a = '0; op_b = '0; op_sub = 1'b0; end
        endcase
    end

    always_comb begin
        sq_bit = 64'(1) << {i_reg, 1'b0};
        sq_t = r_reg + sq_bit;
        sq_ge = v_reg >= sq_t;
        sq_v_next = sq_ge ? v_reg - sq_t : v_reg;
        sq_r_next = sq_ge ? (r_reg >> 1) + sq_bit : r_reg >> 1;
    end

    always_comb begin
        dv_trial = {rem_reg, mag_reg[63]};
        dv_ge = dv_trial >= {1'b0, denom_reg};
        dv_rem_next = dv_ge ? 62'(dv_trial - {1'b0, denom_reg}) : dv_trial[61:0];
        dv_q_next = {q_reg[QUOT_W-2:0], dv_ge};
    end

    assign s_sum = 7'(ka_reg) + 7'(k_reg);

    always_comb begin
        rq = QUOT_W'(({1'b0, q_reg} + (QUOT_W + 1)'(1)) >> 1);
        if (zs_reg) begin
            corr_calc = '0;
        end else if (neg_reg) begin
            if (sat_reg || rq >= QUOT_W'(32768)) begin
                corr_calc = {1'b1, {(CORR_W - 1){1'b0}}};
            end else begin
                corr_calc = CORR_W'(-$signed({1'b0, rq}));
            end
        end else begin
            if (sat_reg || rq >= QUOT_W'(32767)) begin
                corr_calc = {1'b0, {(CORR_W - 1){1'b1}}};
            end else begin
                corr_calc = CORR_W'(rq);
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop = (state_reg == ST_IDLE) && !q_empty;
    assign m_valid = m_valid_reg;
    assign m_correlation = corr_reg;
    assign m_zero_spread = zs_out_reg;
    assign m_pair_count = pc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !(state_reg == ST_DONE && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        ent_reg <= q_data;
                        step_reg <= P_NXX;
                        acc_reg <= '0;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    md_reg <= op_a;
                    mr_reg <= op_b;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    if (mr_reg == '0) begin
                        state_reg <= (step_reg == P_XY) ? ST_CHECK : ST_LOAD;
                        case (step_reg)
                            P_NXX: step_reg <= P_XX;
                            P_XX: begin
                                a_reg <= acc_reg;
                                acc_reg <= '0;
                                step_reg <= P_NYY;
                            end
                            P_NYY: step_reg <= P_YY;
                            P_YY: begin
                                b_reg <= acc_reg;
                                acc_reg <= '0;
                                step_reg <= P_NXY;
                            end
                            P_NXY: step_reg <= P_XY;
                            P_XY: c_reg <= acc_reg;
                            default: step_reg <= P_NXX;
                        endcase
                    end else begin
                        if (mr_reg[0]) begin
                            acc_reg <= op_sub ? acc_reg - md_reg : acc_reg + md_reg;
                        end
                        md_reg <= md_reg << 1;
                        mr_reg <= mr_reg >> 1;
                    end
                end
                ST_CHECK: begin
                    neg_reg <= c_reg[63];
                    mag_reg <= c_reg[63] ? 64'(0) - c_reg : c_reg;
                    sat_reg <= 1'b0;
                    q_reg <= '0;
                    if (a_reg == '0 || b_reg == '0) begin
                        zs_reg <= 1'b1;
                        state_reg <= ST_DONE;
                    end else begin
                        zs_reg <= 1'b0;
                        v_reg <= a_reg;
                        k_reg <= '0;
                        second_reg <= 1'b0;
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    // Bring the value into [2^60, 2^62) two bits at a time.
                    if (v_reg[63:62] != 2'b00) begin
                        v_reg <= v_reg >> 2;
                        k_reg <= k_reg - 6'sd1;
                    end else if (v_reg[63:60] == 4'b0000) begin
                        v_reg <= v_reg << 2;
                        k_reg <= k_reg + 6'sd1;
                    end else begin
                        r_reg <= '0;
                        i_reg <= 5'd31;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_reg <= sq_r_next;
                    i_reg <= i_reg - 5'd1;
                    if (i_reg == '0 && !second_reg) begin
                        root_a_reg <= sq_r_next[30:0];
                        ka_reg <= k_reg;
                        v_reg <= b_reg;
                        k_reg <= '0;
                        second_reg <= 1'b1;
                        state_reg <= ST_NORM;
                    end else begin
                        v_reg <= sq_v_next;
                        if (i_reg == '0) begin
                            root_b_reg <= sq_r_next[30:0];
                            state_reg <= ST_PROD;
                        end
                    end
                end
                ST_PROD: begin
                    denom_reg <= root_a_reg * root_b_reg;
                    rem_reg <= '0;
                    if (s_sum < 0) begin
                        mag_reg <= mag_reg >> (-s_sum);
                        cnt_reg <= 8'(DIV_EXTRA);
                    end else begin
                        cnt_reg <= 8'(DIV_EXTRA) + 8'(s_sum);
                    end
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    mag_reg <= mag_reg << 1;
                    rem_reg <= dv_rem_next;
                    q_reg <= dv_q_next;
                    cnt_reg <= cnt_reg - 8'd1;
                    if (dv_q_next[QUOT_W-1]) begin
                        sat_reg <= 1'b1;
                        state_reg <= ST_DONE;
                    end else if (cnt_reg == 8'd1) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        corr_reg <= corr_calc;
                        zs_out_reg <= zs_reg;
                        pc_reg <= n_e;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_zero_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && zs_out_reg) |-> (corr_reg == '0))
        else $error("flagged result carries a nonzero coefficient");

    a_roots_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROD) |-> (root_a_reg[30] && root_b_reg[30]))
        else $error("square root left its normalized range");

    a_denom_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (denom_reg[61:60] != 2'b00))
        else $error("divisor below its normalized range");

endmodule

>>> dv/pearson_correlation_check.sv
// Checker for the correlation block: watches both channels, predicts results and compares them.
`timescale 1ns / 1ps
module pearson_correlation_check (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  logic signed [15:0] s_x_sample,
    input  logic signed [15:0] s_y_sample,
    input  logic s_last_sample,
    input  logic m_valid,
    input  logic m_ready,
    input  logic signed [15:0] m_correlation,
    input  logic m_zero_spread,
    input  logic [16:0] m_pair_count,
    output int fail_count,
    output int pending_results
);

    localparam longint unsigned PAIR_CAP = 65536;

    typedef struct packed {
        logic signed [15:0] corr;
        logic zero_spread;
        logic [16:0] pairs;
    } corr_result_t;

    corr_result_t expected_q[$];
    bit [63:0] acc_n, acc_x, acc_y, acc_xx, acc_yy, acc_xy;

    assign pending_results = expected_q.size();

    function automatic bit [63:0] normalized_root(input bit [63:0] v, output int k);
        bit [63:0] r, pw;
        int shift;
        shift = 0;
        while (v >= 64'h4000_0000_0000_0000) begin
            v = v >> 2;
            shift--;
        end
        while (v < 64'h1000_0000_0000_0000) begin
            v = v << 2;
            shift++;
        end
        k = shift;
        r = 0;
        pw = 64'h4000_0000_0000_0000;
        while (pw > v) pw = pw >> 2;
        while (pw != 0) begin
            if (v >= r + pw) begin
                v = v - (r + pw);
                r = (r >> 1) + pw;
            end else begin
                r = r >> 1;
            end
            pw = pw >> 2;
        end
        return r;
    endfunction

    task automatic accumulate_pair(input logic signed [15:0] xs, input logic signed [15:0] ys,
                                   input bit last);
        bit [63:0] x, y, n, a, b, c, mag, den, q, rem, rq;
        int ka, kb, s, i;
        bit neg, sat;
        corr_result_t res;
        x = {{48{xs[15]}}, xs};
        y = {{48{ys[15]}}, ys};
        sat = 0;
        if (acc_n < PAIR_CAP) begin
            acc_n++;
            acc_x += x;
            acc_y += y;
            acc_xx += x * x;
            acc_yy += y * y;
            acc_xy += x * y;
        end
        if (!last) return;
        n = acc_n;
        a = n * acc_xx - acc_x * acc_x;
        b = n * acc_yy - acc_y * acc_y;
        c = n * acc_xy - acc_x * acc_y;
        res.pairs = n[16:0];
        if (a == 0 || b == 0) begin
            res.corr = 0;
            res.zero_spread = 1;
        end else begin
            res.zero_spread = 0;
            neg = c[63];
            mag = neg ? (64'd0 - c) : c;
            den = normalized_root(a, ka) * normalized_root(b, kb);
            s = ka + kb;
            if (s < 0) begin
                mag = (-s < 64) ? (mag >> (-s)) : 64'd0;
                s = 0;
            end
            q = mag / den;
            rem = mag % den;
            if (q >= 64'h20000) sat = 1;
            for (i = 0; i < s + 16 && !sat; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    q[0] = 1'b1;
                end
                if (q >= 64'h20000) sat = 1;
            end
            if (sat) begin
                res.corr = neg ? 16'sh8000 : 16'sd32767;
            end else begin
                rq = (q + 1) >> 1;
                if (neg) res.corr = (rq >= 32768) ? 16'sh8000 : 16'(-rq);
                else res.corr = (rq >= 32767) ? 16'sd32767 : 16'(rq);
            end
        end
        expected_q.insert(expected_q.size(), res);
        {acc_n, acc_x, acc_y, acc_xx, acc_yy, acc_xy} = '0;
    endtask

    always @(posedge aclk) begin
        corr_result_t want;
        if (!aresetn) begin
            {acc_n, acc_x, acc_y, acc_xx, acc_yy, acc_xy} = '0;
            expected_q.delete();
        end else begin
            if (s_valid && s_ready)
                accumulate_pair(s_x_sample, s_y_sample, s_last_sample);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request pending: corr %0d", m_correlation);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_correlation !== want.corr) begin
                        $error("correlation: expected %0d, got %0d", want.corr, m_correlation);
                        fail_count++;
                    end
                    if (m_zero_spread !== want.zero_spread) begin
                        $error("zero_spread: expected %0d, got %0d", want.zero_spread,
                               m_zero_spread);
                        fail_count++;
                    end
                    if (m_pair_count !== want.pairs) begin
                        $error("pair_count: expected %0d, got %0d", want.pairs, m_pair_count);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> dv/pearson_correlation_test.sv
// Top of the correlation testbench: clock, reset, stimulus phases and verdict.
`timescale 1ns / 1ps
module pearson_correlation_test;

    localparam int CYCLE_LIMIT = 4000000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [15:0] s_x_sample = 0;
    logic signed [15:0] s_y_sample = 0;
    logic s_last_sample = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [15:0] m_correlation;
    logic m_zero_spread;
    logic [16:0] m_pair_count;

    int fail_count, pending_results;
    int sender_idle_pct = 0, receiver_stall_pct = 0;
    int series_sent = 0, pairs_sent = 0;
    longint cycle_count = 0;

    pearson_correlation i_dut (.*);
    pearson_correlation_check i_check (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk)
        m_ready <= aresetn && ($urandom_range(99) >= receiver_stall_pct);

    // Holds one request on the channel until the block takes it.
    task automatic send_pair(input logic signed [15:0] x, input logic signed [15:0] y,
                             input bit last);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_x_sample <= x;
        s_y_sample <= y;
        s_last_sample <= last;
        do @(posedge aclk); while (!s_ready);
        pairs_sent++;
        if (last) series_sent++;
    endtask

    task automatic send_series(input int len);
        int kind, i, gain, span;
        logic signed [15:0] x, y, x0;
        kind = $urandom_range(5);
        gain = $urandom_range(7) - 3;
        span = 1 << $urandom_range(15, 1);
        x0 = 16'($urandom);
        for (i = 0; i < len; i++) begin
            x = 16'($urandom);
            y = 16'($urandom);
            case (kind)
                0: ;
                1: y = 16'(x * gain + $signed($urandom_range(span)) - span / 2);
                2: x = x0;
                3: begin
                    x = 16'($signed($urandom_range(span)) - span / 2);
                    y = 16'($signed($urandom_range(span)) - span / 2);
                end
                4: begin
                    x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                    y = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                end
                default: y = -x;
            endcase
            send_pair(x, y, i == len - 1);
        end
    endtask

    initial begin
        int p, k;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: a lone pair, perfect positive and negative pairs, flat, short mixed and extreme series.
        send_pair(16'sh1000, 16'sh2000, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b0);
        send_pair(16'sh7fff, 16'sh7fff, 1'b1);
        send_pair(16'sh8000, 16'sh7fff, 1'b0);
        send_pair(16'sh7fff, 16'sh8000, 1'b1);
        send_pair(16'sh0123, 16'sh0001, 1'b0);
        send_pair(16'sh0123, -16'sd5, 1'b0);
        send_pair(16'sh0123, 16'sh0400, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sd1, 16'sd3, 1'b0);
        send_pair(16'sd2, 16'sd1, 1'b0);
        send_pair(16'sd3, 16'sd4, 1'b0);
        send_pair(-16'sd4, 16'sd1, 1'b1);
        send_pair(16'sh7fff, 16'sh8000, 1'b0);
        send_pair(16'sh8000, 16'sh7fff, 1'b0);
        send_pair(16'sh7fff, 16'sh7fff, 1'b1);
        s_valid <= 0;
        wait (pending_results == 0);

        for (p = 0; p < 4; p++) begin
            sender_idle_pct = (p == 1) ? 77 : (p == 3) ? 26 : 0;
            receiver_stall_pct = (p == 2) ? 77 : (p == 3) ? 26 : 0;
            k = pairs_sent;
            while (pairs_sent < k + 350)
                send_series(($urandom_range(9) == 0) ? $urandom_range(2, 1)
                                                     : $urandom_range(40, 2));
        end
        s_valid <= 0;

        wait (pending_results == 0);
        repeat (1000) @(posedge aclk);
        $display("Ran %0d series over %0d sample pairs, from lone pairs to flat and extreme data,",
                 series_sent, pairs_sent);
        $display("under no idling, sender idling, receiver stalls and both together.");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
